FILE: src/ofmd_pkg.sv
// shared types, constants and table functions for the octant force to motor drive block
package ofmd_pkg;

  localparam int FORCE_W    = 8;
  localparam int THETA_W    = 9;
  localparam int DRIVE_W    = 13;
  localparam int NUM_MOTORS = 8;
  localparam int MOTOR_W    = 3;
  localparam int OCT_W      = 3;
  localparam int TIDX_W     = 7;
  localparam int QUARTER    = 90;
  localparam int HALF_TURN  = 180;
  localparam int FULL_TURN  = 360;
  localparam int OCT_SPAN   = 45;
  localparam int PART_MAX   = 10;
  localparam int CMP_BASE   = 2000;
  localparam int CMP_TOP    = 4199;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [MOTOR_W-1:0] motor_t;
  typedef logic [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    logic   diag_cos;
    logic   diag_neg;
    logic   orth_neg;
    motor_t diag_motor;
    motor_t orth_motor;
  } oct_rule_t;

  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic              neg;
  } trig_ref_t;

  // one classified transaction as handed from the front end to the back end
  typedef struct packed {
    logic [FORCE_W-1:0] force_val;
    logic [TIDX_W-1:0]  t_idx;
    logic               t_neg;
    logic [TIDX_W-1:0]  u_idx;
    logic               u_neg;
    motor_t             diag_motor;
    motor_t             orth_motor;
  } job_t;

  typedef struct packed {
    logic push;
  } q_ctl_t;

  function automatic oct_rule_t rule_of(input logic [OCT_W-1:0] oct);
    oct_rule_t r;
    case (oct)
      3'd0:    r = '{1'b0, 1'b0, 1'b0, 3'd1, 3'd0};
      3'd1:    r = '{1'b1, 1'b0, 1'b0, 3'd1, 3'd2};
      3'd2:    r = '{1'b1, 1'b1, 1'b0, 3'd2, 3'd3};
      3'd3:    r = '{1'b0, 1'b0, 1'b1, 3'd3, 3'd4};
      3'd4:    r = '{1'b0, 1'b1, 1'b1, 3'd4, 3'd5};
      3'd5:    r = '{1'b1, 1'b1, 1'b1, 3'd5, 3'd6};
      3'd6:    r = '{1'b1, 1'b0, 1'b1, 3'd6, 3'd7};
      default: r = '{1'b0, 1'b1, 1'b0, 3'd7, 3'd0};
    endcase
    return r;
  endfunction

  // angle in 0..359 folded onto the first quadrant with a sign
  function automatic trig_ref_t fold_angle(input logic [THETA_W-1:0] a);
    trig_ref_t         t;
    logic [THETA_W-1:0] h;
    t.neg = (a >= THETA_W'(HALF_TURN));
    h     = t.neg ? a - THETA_W'(HALF_TURN) : a;
    t.idx = (h > THETA_W'(QUARTER)) ? TIDX_W'(THETA_W'(HALF_TURN) - h) : TIDX_W'(h);
    return t;
  endfunction

  // taylor series sine of r degrees in q30, evaluated at elaboration only
  function automatic longint q30_sine(input int r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'(r) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  function automatic drive_t cmp_of(input logic [3:0] n);
    drive_t d;
    case (n)
      4'd0:    d = 13'd2000;
      4'd1:    d = 13'd2219;
      4'd2:    d = 13'd2439;
      4'd3:    d = 13'd2659;
      4'd4:    d = 13'd2879;
      4'd5:    d = 13'd3099;
      4'd6:    d = 13'd3319;
      4'd7:    d = 13'd3539;
      4'd8:    d = 13'd3759;
      4'd9:    d = 13'd3979;
      default: d = 13'd4199;
    endcase
    return d;
  endfunction

endpackage

FILE: src/ofmd_front.sv
// front end: accepts commands, finds the octant and the folded trig references
module ofmd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ofmd_pkg::FORCE_W-1:0] in_force_req,
  input  logic [ofmd_pkg::THETA_W-1:0] in_theta,
  input  logic                         q_full,
  output ofmd_pkg::q_ctl_t             q_ctl,
  output ofmd_pkg::job_t               q_job
);
  import ofmd_pkg::*;

  logic                 f_valid_r, f_valid_nxt;
  job_t                 f_job_r, f_job_nxt;
  logic                 accept, advance;
  logic [OCT_W-1:0]     oct;
  logic [THETA_W-1:0]   s_ang;
  logic [THETA_W:0]     c_sum;
  logic [THETA_W-1:0]   c_ang;
  trig_ref_t            s_ref, c_ref;
  oct_rule_t            rule;

  always_comb begin
    oct = '0;
    for (int k = 1; k < NUM_MOTORS; k++) begin
      oct = oct + OCT_W'(in_theta >= THETA_W'(OCT_SPAN * k));
    end
    s_ang = (in_theta >= THETA_W'(FULL_TURN)) ? in_theta - THETA_W'(FULL_TURN) : in_theta;
    c_sum = {1'b0, in_theta} + (THETA_W + 1)'(QUARTER);
    c_ang = (c_sum >= (THETA_W + 1)'(FULL_TURN)) ? THETA_W'(c_sum - (THETA_W + 1)'(FULL_TURN))
                                                 : THETA_W'(c_sum);
    s_ref = fold_angle(s_ang);
    c_ref = fold_angle(c_ang);
    rule  = rule_of(oct);

    f_job_nxt.force_val  = in_force_req;
    f_job_nxt.t_idx      = rule.diag_cos ? c_ref.idx : s_ref.idx;
    f_job_nxt.t_neg      = (rule.diag_cos ? c_ref.neg : s_ref.neg) ^ rule.diag_neg;
    f_job_nxt.u_idx      = rule.diag_cos ? s_ref.idx : c_ref.idx;
    f_job_nxt.u_neg      = (rule.diag_cos ? s_ref.neg : c_ref.neg) ^ rule.orth_neg;
    f_job_nxt.diag_motor = rule.diag_motor;
    f_job_nxt.orth_motor = rule.orth_motor;
  end

  assign busy        = f_valid_r && q_full;
  assign accept      = start && !busy;
  assign advance     = !f_valid_r || !q_full;
  assign f_valid_nxt = advance ? accept : f_valid_r;

  assign q_ctl.push = f_valid_r && !q_full;
  assign q_job      = f_job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_job_r <= f_job_nxt;
    end
  end

endmodule

FILE: src/ofmd_queue.sv
// short transaction queue between the front end and the back end
module ofmd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ofmd_pkg::q_ctl_t q_ctl,
  input  ofmd_pkg::job_t   push_job,
  output logic             full,
  output logic             pop_valid,
  output ofmd_pkg::job_t   pop_job
);
  import ofmd_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid;
  assign pop_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (q_ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(q_ctl.push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: src/ofmd_back.sv
// back end: sine lookup, part products, compare mapping and motor routing
module ofmd_back #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  ofmd_pkg::job_t   job,
  output logic             res_valid,
  output ofmd_pkg::drive_t drive [ofmd_pkg::NUM_MOTORS]
);
  import ofmd_pkg::*;

  localparam int S     = TRIG_FRAC_BITS;
  localparam int ROM_W = (QUARTER + 1) * (S + 1);
  localparam int P_W   = FORCE_W + S + 1;
  localparam int Q_W   = FORCE_W + S + 2;
  localparam int THR_W = PART_MAX * P_W;

  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] rom;
    longint           sum;
    logic [63:0]      v;
    rom = '0;
    for (int r = 0; r <= QUARTER; r++) begin
      sum = q30_sine(r);
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) + (64'd1 << (29 - S))) >> (30 - S);
      if (v > (64'd1 << S)) begin
        v = 64'd1 << S;
      end
      rom[r * (S + 1) +: (S + 1)] = v[S:0];
    end
    return rom;
  endfunction

  // diagonal part reaches k once force*t*1000 >= k*707*2^S
  function automatic logic [THR_W-1:0] build_thr();
    logic [THR_W-1:0] thr;
    longint           num;
    longint           q;
    thr = '0;
    for (int k = 1; k <= PART_MAX; k++) begin
      num = longint'(k) * 707 * (longint'(1) << S);
      q   = (num + 999) / 1000;
      thr[(k - 1) * P_W +: P_W] = P_W'(q);
    end
    return thr;
  endfunction

  localparam logic [ROM_W-1:0] SINE_ROM = build_rom();
  localparam logic [THR_W-1:0] DIAG_THR = build_thr();

  // stage 1: table lookup with signs applied
  logic                      v1_r;
  logic signed [S+1:0]       ts_r, ts_nxt, us_r, us_nxt;
  logic [FORCE_W-1:0]        f1_r;
  motor_t                    dm1_r, om1_r;
  logic [S:0]                t_rom, u_rom;

  // stage 2: non-negative operands
  logic                      v2_r;
  logic [S:0]                dmag_r, dmag_nxt;
  logic [S+1:0]              wmag_r, wmag_nxt;
  logic signed [S+2:0]       w;
  logic [FORCE_W-1:0]        f2_r;
  motor_t                    dm2_r, om2_r;

  // stage 3: products
  logic                      v3_r;
  logic [P_W-1:0]            p_r, p_nxt;
  logic [Q_W-1:0]            q_r, q_nxt;
  motor_t                    dm3_r, om3_r;

  // stage 4: mapping and routing
  logic                      v4_r;
  drive_t                    drv_r [NUM_MOTORS];
  drive_t                    drv_nxt [NUM_MOTORS];
  logic [3:0]                n_d, n_o;
  logic [Q_W-S-1:0]          q_hi;

  always_comb begin
    t_rom  = SINE_ROM[job.t_idx * (S + 1) +: (S + 1)];
    u_rom  = SINE_ROM[job.u_idx * (S + 1) +: (S + 1)];
    ts_nxt = job.t_neg ? -$signed({1'b0, t_rom}) : $signed({1'b0, t_rom});
    us_nxt = job.u_neg ? -$signed({1'b0, u_rom}) : $signed({1'b0, u_rom});
  end

  always_comb begin
    w        = $signed({us_r[S+1], us_r}) - $signed({ts_r[S+1], ts_r});
    dmag_nxt = (ts_r > 0) ? ts_r[S:0] : '0;
    wmag_nxt = (w > 0) ? w[S+1:0] : '0;
  end

  always_comb begin
    p_nxt = P_W'(f2_r) * P_W'(dmag_r);
    q_nxt = Q_W'(f2_r) * Q_W'(wmag_r);
  end

  always_comb begin
    n_d = '0;
    for (int k = 0; k < PART_MAX; k++) begin
      n_d = n_d + 4'(p_r >= DIAG_THR[k * P_W +: P_W]);
    end
    q_hi = q_r[Q_W-1:S];
    n_o  = (q_hi > (Q_W - S)'(PART_MAX)) ? 4'(PART_MAX) : q_hi[3:0];
    for (int m = 0; m < NUM_MOTORS; m++) begin
      drv_nxt[m] = '0;
    end
    drv_nxt[dm3_r] = cmp_of(n_d);
    drv_nxt[om3_r] = cmp_of(n_o);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= job_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ts_r   <= ts_nxt;
    us_r   <= us_nxt;
    f1_r   <= job.force_val;
    dm1_r  <= job.diag_motor;
    om1_r  <= job.orth_motor;
    dmag_r <= dmag_nxt;
    wmag_r <= wmag_nxt;
    f2_r   <= f1_r;
    dm2_r  <= dm1_r;
    om2_r  <= om1_r;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    dm3_r  <= dm2_r;
    om3_r  <= om2_r;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      drv_r[m] <= drv_nxt[m];
    end
  end

  assign res_valid = v4_r;
  assign drive     = drv_r;

endmodule

FILE: src/octant_force_to_motor_drive_core.sv
// top level of the octant force to motor drive block
//
//  channel   handshake         payload
//  command   start / busy      in_force_req[7:0], in_theta[8:0]
//  result    out_valid strobe  out_drive_1 .. out_drive_8 [12:0]
//
// one command per cycle is taken while busy is low; the back end pipeline never stalls
// each result strobes for one cycle
// a result passes the front register, a queue slot and four back end stages
// busy rises only with the queue full and the front register loaded
// synchronous active low reset empties the front register, queue and pipeline
module octant_force_to_motor_drive_core #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ofmd_pkg::FORCE_W-1:0] in_force_req,
  input  logic [ofmd_pkg::THETA_W-1:0] in_theta,
  output logic                         out_valid,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_1,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_2,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_3,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_4,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_5,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_6,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_7,
  output logic [ofmd_pkg::DRIVE_W-1:0] out_drive_8
);
  import ofmd_pkg::*;

  q_ctl_t q_ctl;
  job_t   q_in_job, q_out_job;
  logic   q_full, q_valid;
  drive_t drive [NUM_MOTORS];

  ofmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_force_req (in_force_req),
    .in_theta     (in_theta),
    .q_full       (q_full),
    .q_ctl        (q_ctl),
    .q_job        (q_in_job)
  );

  ofmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (q_ctl),
    .push_job  (q_in_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_out_job)
  );

  ofmd_back #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_out_job),
    .res_valid (out_valid),
    .drive     (drive)
  );

  assign out_drive_1 = drive[0];
  assign out_drive_2 = drive[1];
  assign out_drive_3 = drive[2];
  assign out_drive_4 = drive[3];
  assign out_drive_5 = drive[4];
  assign out_drive_6 = drive[5];
  assign out_drive_7 = drive[6];
  assign out_drive_8 = drive[7];

endmodule

FILE: src/ofmd_checker.sv
// port level checks for the octant force to motor drive block, with its bind
module ofmd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_1,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_2,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_3,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_4,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_5,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_6,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_7,
  input logic [ofmd_pkg::DRIVE_W-1:0] out_drive_8
);
  import ofmd_pkg::*;

  function automatic logic drv_ok(input drive_t d);
    return (d == '0) || ((d >= DRIVE_W'(CMP_BASE)) && (d <= DRIVE_W'(CMP_TOP)));
  endfunction

  logic [NUM_MOTORS-1:0] active;
  logic                  range_ok;

  assign active = {out_drive_8 != '0, out_drive_7 != '0, out_drive_6 != '0,
                   out_drive_5 != '0, out_drive_4 != '0, out_drive_3 != '0,
                   out_drive_2 != '0, out_drive_1 != '0};

  assign range_ok = drv_ok(out_drive_1) && drv_ok(out_drive_2) && drv_ok(out_drive_3) &&
                    drv_ok(out_drive_4) && drv_ok(out_drive_5) && drv_ok(out_drive_6) &&
                    drv_ok(out_drive_7) && drv_ok(out_drive_8);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result strobe or busy after reset");

  a_fwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("command transaction without its result");

  a_bwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result transaction without a command");

  a_two_motors: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(active) == 2)
    else $error("result does not drive exactly two motors");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> range_ok)
    else $error("compare value out of range");

endmodule

bind octant_force_to_motor_drive_core ofmd_checker u_ofmd_checker (.*);
